>>> design/fbd_pkg.sv
// Shared types, codes and helper functions of the framebuffer draw engine.
`default_nettype none
package fbd_pkg;

    localparam int CRD_W          = 12;
    localparam int ADDR_W         = 22;
    localparam int SQ_W           = 28;
    localparam int PIX_W          = 32;
    localparam int CFG_W          = 9;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [2:0] FUNC_FILL_RECT = 3'd0;
    localparam logic [2:0] FUNC_FILL_DISC = 3'd1;
    localparam logic [2:0] FUNC_BLIT_COPY = 3'd2;
    localparam logic [2:0] FUNC_BLIT_ALPHA = 3'd3;
    localparam logic [2:0] FUNC_SRC_PIXEL = 3'd4;
    localparam logic [2:0] FUNC_READ      = 3'd5;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        K_FILL  = 2'd0,
        K_WRITE = 2'd1,
        K_DONE  = 2'd2,
        K_READ  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     disc;
        logic                     alpha;
        logic                     done;
        logic                     visible;
        logic [CRD_W-1:0]         x0;
        logic [CRD_W-1:0]         x1;
        logic [CRD_W-1:0]         y0;
        logic [CRD_W-1:0]         y1;
        logic signed [CRD_W-1:0]  cx;
        logic signed [CRD_W-1:0]  cy;
        logic signed [CRD_W-1:0]  r;
        logic [ADDR_W-1:0]        addr;
        logic [PIX_W-1:0]         pixel;
    } entry_t;

    function automatic logic [SQ_W-1:0] square14(input logic signed [13:0] v);
        logic signed [27:0] p;
        p = v * v;
        return SQ_W'(p);
    endfunction

    // Each of B, G, R becomes min(255, (dst * (256 - alpha)) >> 8 + src).
    function automatic logic [PIX_W-1:0] alpha_add(input logic [PIX_W-1:0] src,
                                                  input logic [PIX_W-1:0] dst);
        logic [8:0]  keep;
        logic [16:0] prod;
        logic [9:0]  c;
        logic [PIX_W-1:0] res;
        keep = 9'd256 - {1'b0, src[31:24]};
        res = {src[31:24], 24'd0};
        for (int i = 0; i < 3; i++) begin
            prod = dst[i*8 +: 8] * keep;
            c = {1'b0, prod[16:8]} + {2'b0, src[i*8 +: 8]};
            res[i*8 +: 8] = (c > 10'd255) ? 8'hFF : c[7:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> design/fbd_if.sv
// Request and result channel interfaces of the framebuffer draw engine.
`default_nettype none
interface fbd_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [11:0] x_a;
    logic signed [11:0] y_a;
    logic signed [11:0] x_b;
    logic signed [11:0] y_b;
    logic [31:0]        pixel_in;
    modport source (output valid, func, x_a, y_a, x_b, y_b, pixel_in, input ready);
    modport sink (input valid, func, x_a, y_a, x_b, y_b, pixel_in, output ready);
endinterface

interface fbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_pixel;
    logic        command_done;
    modport source (output valid, read_pixel, command_done, input ready);
    modport sink (input valid, read_pixel, command_done, output ready);
endinterface
`default_nettype wire

>>> design/framebuffer_draw_engine.sv
// Top level of the framebuffer draw engine: front end, queue and back end.
//
//   channel | direction | contents
//   --------+-----------+---------------------------------------------------
//   cmd     | in        | func, x_a, y_a, x_b, y_b, pixel_in (one request)
//   rsp     | out       | read_pixel, command_done (at most one per request)
//   cfg     | in        | cfg_we, cfg_index, cfg_data (frame width/height)
//
// Steps: a copy-blit source pixel is written straight from the queue head;
// an alpha-blit pixel is dequeued, read from memory, then written back blended
// through the single frame memory write port; a pixel that ends a blit then
// posts its result. A fill is dequeued and set up, then walks its clipped box
// at one pixel per cycle and posts its result. A read is dequeued, reads memory
// and posts its result. Requests enter the queue at one a cycle while it has room.
// Reset clears the control state at once; the frame memory is not cleared.
// A stalled result holds in the output register and stalls the back end; the
// front end stalls once the queue has filled behind it.
`default_nettype none
module framebuffer_draw_engine #(
    parameter int MAX_WIDTH  = fbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_we,
    input  wire                       cfg_index,
    input  wire [fbd_pkg::CFG_W-1:0]  cfg_data,
    fbd_req_if.sink                   cmd,
    fbd_rsp_if.source                 rsp
);
    import fbd_pkg::*;

    // Classified requests travel from the front end to the back end as entries.
    entry_t           enq_entry, head_entry;
    logic             q_push, q_pop, q_full, q_empty;
    logic [CRD_W-1:0] eff_w, eff_h;

    fbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (enq_entry),
        .eff_w     (eff_w),
        .eff_h     (eff_h)
    );

    fbd_fifo #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (enq_entry),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_entry),
        .empty (q_empty)
    );

    // The back end walks fills and owns the frame memory and the result register.
    fbd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (head_entry),
        .q_pop   (q_pop),
        .eff_w   (eff_w),
        .eff_h   (eff_h),
        .rsp     (rsp)
    );
endmodule
`default_nettype wire

>>> design/fbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> design/fbd_fifo.sv
// Small queue between the command front end and the pixel back end.
`default_nettype none
module fbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  din,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = slot[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[wr_ptr_reg] <= din;
        end
    end
endmodule
`default_nettype wire

>>> design/fbd_front.sv
// Front end: configuration, blit tracking, clipping and address forming.
`default_nettype none
module fbd_front #(
    parameter int MAX_WIDTH  = fbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire [fbd_pkg::CFG_W-1:0]     cfg_data,
    fbd_req_if.sink                      cmd,
    input  wire                          q_full,
    output logic                         q_push,
    output fbd_pkg::entry_t              q_entry,
    output logic [fbd_pkg::CRD_W-1:0]    eff_w,
    output logic [fbd_pkg::CRD_W-1:0]    eff_h
);
    import fbd_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_COPY  = 2'd1;
    localparam logic [1:0] MODE_ALPHA = 2'd2;

    logic [CFG_W-1:0]        fw_reg, fh_reg;
    logic [1:0]              mode_reg, mode_next;
    logic signed [CRD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [10:0]             bw_reg, bw_next, bh_reg, bh_next;
    logic [10:0]             col_reg, col_next, row_reg, row_next;
    logic                    accept;
    logic signed [13:0]      px, py, ex, ey, lo_x, hi_x, lo_y, hi_y;
    logic                    in_frame;
    logic [CRD_W-1:0]        row_idx;
    logic [2*CRD_W-1:0]      row_prod;
    logic [ADDR_W-1:0]       addr;
    logic                    last_col, last_row;

    function automatic logic [CRD_W-1:0] clampc(input logic signed [13:0] v,
                                                input logic [CRD_W-1:0] hi);
        if (v < 14'sd0)
        begin
            return '0;
        end
        else if (v > signed'({2'b00, hi}))
        begin
            return hi;
        end
        return v[CRD_W-1:0];
    endfunction

    function automatic logic signed [13:0] sx(input logic signed [CRD_W-1:0] v);
        return {{2{v[CRD_W-1]}}, v};
    endfunction

    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = CRD_W'(1);
        end
        else if ({3'b000, fw_reg} > CRD_W'(MAX_WIDTH))
        begin
            eff_w = CRD_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = {3'b000, fw_reg};
        end
        if (fh_reg == '0)
        begin
            eff_h = CRD_W'(1);
        end
        else if ({3'b000, fh_reg} > CRD_W'(MAX_HEIGHT))
        begin
            eff_h = CRD_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = {3'b000, fh_reg};
        end
    end

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    // Pixel position: blit cursor for source pixels, the request itself for reads.
    always_comb
    begin
        if (cmd.func == FUNC_SRC_PIXEL)
        begin
            px = sx(ox_reg) + signed'({3'b000, col_reg});
            py = sx(oy_reg) + signed'({3'b000, row_reg});
        end
        else
        begin
            px = sx(cmd.x_a);
            py = sx(cmd.y_a);
        end
        in_frame = (px >= 14'sd0) && (px < signed'({2'b00, eff_w}))
                && (py >= 14'sd0) && (py < signed'({2'b00, eff_h}));
        row_idx  = eff_h - CRD_W'(1) - py[CRD_W-1:0];
        row_prod = row_idx * eff_w;
        addr     = ADDR_W'(row_prod + {{CRD_W{1'b0}}, px[CRD_W-1:0]});
        last_col = ({1'b0, col_reg} + 12'd1) >= {1'b0, bw_reg};
        last_row = ({1'b0, row_reg} + 12'd1) >= {1'b0, bh_reg};
    end

    always_comb
    begin
        ex   = sx(cmd.x_a) - sx(cmd.x_b);
        ey   = sx(cmd.y_a) - sx(cmd.x_b);
        lo_x = (cmd.x_a < cmd.x_b) ? sx(cmd.x_a) : sx(cmd.x_b);
        hi_x = (cmd.x_a < cmd.x_b) ? sx(cmd.x_b) : sx(cmd.x_a);
        lo_y = (cmd.y_a < cmd.y_b) ? sx(cmd.y_a) : sx(cmd.y_b);
        hi_y = (cmd.y_a < cmd.y_b) ? sx(cmd.y_b) : sx(cmd.y_a);

        q_entry         = '0;
        q_entry.cx      = cmd.x_a;
        q_entry.cy      = cmd.y_a;
        q_entry.r       = cmd.x_b;
        q_entry.pixel   = cmd.pixel_in;
        q_entry.addr    = addr;
        q_entry.visible = in_frame;
        q_entry.kind    = K_DONE;
        q_push          = 1'b0;

        mode_next = mode_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        bw_next   = bw_reg;
        bh_next   = bh_reg;
        col_next  = col_reg;
        row_next  = row_reg;

        unique case (cmd.func) inside
            FUNC_FILL_RECT:
            begin
                q_push       = accept;
                q_entry.kind = K_FILL;
                q_entry.x0   = clampc(lo_x, eff_w);
                q_entry.x1   = clampc(hi_x, eff_w);
                q_entry.y0   = clampc(lo_y, eff_h);
                q_entry.y1   = clampc(hi_y, eff_h);
            end
            FUNC_FILL_DISC:
            begin
                q_push       = accept;
                q_entry.kind = K_FILL;
                q_entry.disc = 1'b1;
                q_entry.x0   = clampc(ex, eff_w);
                q_entry.x1   = clampc(sx(cmd.x_a) + sx(cmd.x_b), eff_w);
                q_entry.y0   = clampc(ey, eff_h);
                q_entry.y1   = clampc(sx(cmd.y_a) + sx(cmd.x_b), eff_h);
            end
            FUNC_BLIT_COPY, FUNC_BLIT_ALPHA:
            begin
                ox_next  = cmd.x_a;
                oy_next  = cmd.y_a;
                bw_next  = cmd.x_b[CRD_W-1] ? 11'd0 : cmd.x_b[10:0];
                bh_next  = cmd.y_b[CRD_W-1] ? 11'd0 : cmd.y_b[10:0];
                col_next = '0;
                row_next = '0;
                if (bw_next == '0 || bh_next == '0)
                begin
                    mode_next = MODE_IDLE;
                    q_push    = accept;
                end
                else
                begin
                    mode_next = (cmd.func == FUNC_BLIT_COPY) ? MODE_COPY : MODE_ALPHA;
                end
            end
            FUNC_SRC_PIXEL:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    q_entry.alpha = (mode_reg == MODE_ALPHA);
                    q_entry.done  = last_col && last_row;
                    if (in_frame)
                    begin
                        q_entry.kind = K_WRITE;
                        q_push       = accept;
                    end
                    else
                    begin
                        q_push = accept && q_entry.done;
                    end
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = row_reg + 11'd1;
                        if (last_row)
                        begin
                            row_next  = '0;
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 11'd1;
                    end
                end
            end
            FUNC_READ:
            begin
                q_push       = accept;
                q_entry.kind = K_READ;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= CFG_W'(256);
            fh_reg   <= CFG_W'(256);
            mode_reg <= MODE_IDLE;
            ox_reg   <= '0;
            oy_reg   <= '0;
            bw_reg   <= '0;
            bh_reg   <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_IDX_WIDTH)
            begin
                fw_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_IDX_HEIGHT)
            begin
                fh_reg <= cfg_data;
            end
            if (accept)
            begin
                mode_reg <= mode_next;
                ox_reg   <= ox_next;
                oy_reg   <= oy_next;
                bw_reg   <= bw_next;
                bh_reg   <= bh_next;
                col_reg  <= col_next;
                row_reg  <= row_next;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/fbd_back.sv
// Back end: walks fills, performs pixel writes, blends and reads, drives results.
`default_nettype none
module fbd_back #(
    parameter int MAX_WIDTH  = fbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbd_pkg::DEF_MAX_HEIGHT
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        q_empty,
    input  fbd_pkg::entry_t            q_head,
    output logic                       q_pop,
    input  wire [fbd_pkg::CRD_W-1:0]   eff_w,
    input  wire [fbd_pkg::CRD_W-1:0]   eff_h,
    fbd_rsp_if.source                  rsp
);
    import fbd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_ALRD = 3'd3;
    localparam logic [2:0] S_ALWR = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]        state_reg, state_next;
    entry_t            cur_reg, cur_next;
    logic [CRD_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SQ_W-1:0]   dy2_reg, dy2_next;
    logic [23:0]       r2_reg, r2_next;
    logic              rv_reg, rv_next;
    logic [PIX_W-1:0]  rp_reg, rp_next;
    logic              rd_reg, rd_next;

    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [PIX_W-1:0]  wdata, rdata;
    logic signed [13:0] dx, dy_n;
    logic [SQ_W-1:0]   dx2;
    logic              hit;
    logic [2*CRD_W-1:0] base_prod;
    logic signed [23:0] rr;

    fbd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rsp.valid        = rv_reg;
    assign rsp.read_pixel   = rp_reg;
    assign rsp.command_done = rd_reg;

    always_comb
    begin
        dx        = signed'({2'b00, x_reg}) - {{2{cur_reg.cx[CRD_W-1]}}, cur_reg.cx};
        dy_n      = signed'({2'b00, y_reg}) + 14'sd1
                  - {{2{cur_reg.cy[CRD_W-1]}}, cur_reg.cy};
        dx2       = square14(dx);
        hit       = !cur_reg.disc
                 || (({1'b0, dx2} + {1'b0, dy2_reg}) < {5'd0, r2_reg});
        base_prod = (eff_h - CRD_W'(1) - cur_reg.y0) * eff_w;
        rr        = cur_reg.r * cur_reg.r;
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        base_next  = base_reg;
        dy2_next   = dy2_reg;
        r2_next    = r2_reg;
        rv_next    = rv_reg && !rsp.ready;
        rp_next    = rp_reg;
        rd_next    = rd_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = cur_reg.addr[AW-1:0];
        wdata      = cur_reg.pixel;
        raddr      = cur_reg.addr[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    unique case (q_head.kind)
                        K_FILL:  state_next = S_PREP;
                        K_READ:  state_next = S_READ;
                        K_DONE:  state_next = S_RESP;
                        default:
                        begin
                            if (q_head.alpha)
                            begin
                                state_next = S_ALRD;
                            end
                            else
                            begin
                                // Copy pixels go straight to memory from the queue head.
                                we         = 1'b1;
                                waddr      = q_head.addr[AW-1:0];
                                wdata      = q_head.pixel;
                                state_next = q_head.done ? S_RESP : S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_PREP:
            begin
                if (cur_reg.x0 >= cur_reg.x1 || cur_reg.y0 >= cur_reg.y1)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    base_next  = ADDR_W'(base_prod);
                    x_next     = cur_reg.x0;
                    y_next     = cur_reg.y0;
                    dy2_next   = square14(signed'({2'b00, cur_reg.y0})
                               - {{2{cur_reg.cy[CRD_W-1]}}, cur_reg.cy});
                    r2_next    = 24'(rr);
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                we    = hit;
                waddr = AW'(base_reg + {{(ADDR_W-CRD_W){1'b0}}, x_reg});
                if (x_reg + CRD_W'(1) == cur_reg.x1)
                begin
                    x_next    = cur_reg.x0;
                    y_next    = y_reg + CRD_W'(1);
                    base_next = base_reg - {{(ADDR_W-CRD_W){1'b0}}, eff_w};
                    dy2_next  = square14(dy_n);
                    if (y_reg + CRD_W'(1) == cur_reg.y1)
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    x_next = x_reg + CRD_W'(1);
                end
            end
            S_ALRD:
            begin
                re         = 1'b1;
                state_next = S_ALWR;
            end
            S_ALWR:
            begin
                we         = 1'b1;
                wdata      = alpha_add(cur_reg.pixel, rdata);
                state_next = cur_reg.done ? S_RESP : S_IDLE;
            end
            S_READ:
            begin
                re         = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rv_reg || rsp.ready)
                begin
                    rv_next    = 1'b1;
                    rd_next    = (cur_reg.kind != K_READ);
                    rp_next    = (cur_reg.kind == K_READ && cur_reg.visible) ? rdata : '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        base_reg <= base_next;
        dy2_reg  <= dy2_next;
        r2_reg   <= r2_next;
        rp_reg   <= rp_next;
        rd_reg   <= rd_next;
    end
endmodule
`default_nettype wire

>>> design/fbd_checker.sv
// Port-level checker of the framebuffer draw engine and its bind.
`default_nettype none
module fbd_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [31:0] rsp_read_pixel,
    input wire        rsp_command_done
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_read_pixel) && $stable(rsp_command_done))
        else $error("stalled result changed");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_command_done |-> rsp_read_pixel == 32'd0)
        else $error("completion result carries pixel data");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !rsp_valid)
        else $error("result right after reset");
endmodule

bind framebuffer_draw_engine fbd_checker u_fbd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_read_pixel   (rsp.read_pixel),
    .rsp_command_done (rsp.command_done)
);
`default_nettype wire

>>> tb/tb_framebuffer_draw_engine.sv
// Self-checking testbench for the framebuffer draw engine top level.
`default_nettype none
module tb_framebuffer_draw_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import fbd_pkg::*;

    localparam int  STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN_CYCLES = 40;
    localparam logic [2:0] FUNC_NONE_6 = 3'd6;
    localparam logic [2:0] FUNC_NONE_7 = 3'd7;

    typedef enum int {
        BLIT_IDLE  = 0,
        BLIT_COPY  = 1,
        BLIT_ALPHA = 2
    } blit_mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] read_pixel;
        logic             command_done;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    fbd_req_if cmd ();
    fbd_rsp_if rsp ();

    framebuffer_draw_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd.sink),
        .rsp      (rsp.source)
    );

    // Shadow copy of the engine: frame contents, frame size registers and the
    // progress of the blit in flight.
    logic [PIX_W-1:0] shadow_frame [STORE_DEPTH];
    int               shadow_width;
    int               shadow_height;
    int               blit_x0;
    int               blit_y0;
    int               blit_w;
    int               blit_h;
    int               blit_col;
    int               blit_row;
    blit_mode_t       blit_mode;

    result_t pending_results [$];
    int      error_count;
    int      cycle_count;
    int      burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A run that hangs is stopped here rather than left to spin forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int frame_w();
        return shadow_width < 1 ? 1 : (shadow_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : shadow_width);
    endfunction

    function automatic int frame_h();
        return shadow_height < 1 ? 1 :
               (shadow_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : shadow_height);
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // The frame is stored bottom-up, so row zero sits at the top of memory.
    function automatic int pixel_addr(int x, int y);
        return ((frame_h() - 1 - y) * frame_w() + x) % STORE_DEPTH;
    endfunction

    function automatic logic [PIX_W-1:0] blend_add(logic [PIX_W-1:0] src,
                                                   logic [PIX_W-1:0] dst);
        int               keep;
        int               chan;
        logic [PIX_W-1:0] out;
        keep = 256 - int'(src[31:24]);
        out = {src[31:24], 24'd0};
        for (int k = 0; k < 3; k++)
        begin
            chan = ((int'(dst[k*8 +: 8]) * keep) >> 8) + int'(src[k*8 +: 8]);
            out[k*8 +: 8] = chan > 255 ? 8'hFF : chan[7:0];
        end
        return out;
    endfunction

    task automatic paint_box(int x0, int y0, int x1, int y1, bit disc,
                             int cx, int cy, int r, logic [PIX_W-1:0] colour);
        longint r2;
        longint dx;
        longint dy;
        r2 = longint'(r) * r;
        x0 = clip(x0, 0, frame_w());
        x1 = clip(x1, 0, frame_w());
        y0 = clip(y0, 0, frame_h());
        y1 = clip(y1, 0, frame_h());
        for (int y = y0; y < y1; y++)
        begin
            for (int x = x0; x < x1; x++)
            begin
                dx = x - cx;
                dy = y - cy;
                if (!disc || dx * dx + dy * dy < r2)
                    shadow_frame[pixel_addr(x, y)] = colour;
            end
        end
    endtask

    // Applies one accepted request to the shadow state and queues the result
    // that it must produce, if any.
    task automatic apply_request(logic [2:0] func, int xa, int ya, int xb, int yb,
                                 logic [PIX_W-1:0] pix);
        result_t r;
        int      px;
        int      py;
        int      a;
        r.read_pixel = '0;
        r.command_done = 1'b1;
        case (func)
            FUNC_FILL_RECT:
            begin
                paint_box(xa < xb ? xa : xb, ya < yb ? ya : yb,
                          xa > xb ? xa : xb, ya > yb ? ya : yb, 1'b0, 0, 0, 0, pix);
                pending_results.push_back(r);
            end
            FUNC_FILL_DISC:
            begin
                paint_box(xa - xb, ya - xb, xa + xb, ya + xb, 1'b1, xa, ya, xb, pix);
                pending_results.push_back(r);
            end
            FUNC_BLIT_COPY, FUNC_BLIT_ALPHA:
            begin
                blit_x0 = xa;
                blit_y0 = ya;
                blit_w = xb < 0 ? 0 : xb;
                blit_h = yb < 0 ? 0 : yb;
                blit_col = 0;
                blit_row = 0;
                if (blit_w == 0 || blit_h == 0)
                begin
                    blit_mode = BLIT_IDLE;
                    pending_results.push_back(r);
                end
                else
                    blit_mode = func == FUNC_BLIT_COPY ? BLIT_COPY : BLIT_ALPHA;
            end
            FUNC_SRC_PIXEL:
            begin
                if (blit_mode != BLIT_IDLE)
                begin
                    px = blit_x0 + blit_col;
                    py = blit_y0 + blit_row;
                    if (px >= 0 && px < frame_w() && py >= 0 && py < frame_h())
                    begin
                        a = pixel_addr(px, py);
                        shadow_frame[a] = blit_mode == BLIT_COPY ? pix
                                                                 : blend_add(pix, shadow_frame[a]);
                    end
                    blit_col++;
                    if (blit_col >= blit_w)
                    begin
                        blit_col = 0;
                        blit_row++;
                        if (blit_row >= blit_h)
                        begin
                            blit_row = 0;
                            blit_mode = BLIT_IDLE;
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                r.command_done = 1'b0;
                if (xa >= 0 && xa < frame_w() && ya >= 0 && ya < frame_h())
                    r.read_pixel = shadow_frame[pixel_addr(xa, ya)];
                pending_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Sends one request. The sender works in bursts; between bursts it drops
    // valid for a random gap. Valid is only ever assigned once per edge.
    task automatic send_request(logic [2:0] func, int xa, int ya, int xb, int yb,
                                logic [PIX_W-1:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                cmd.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        cmd.valid <= 1'b1;
        cmd.func <= func;
        cmd.x_a <= xa[11:0];
        cmd.y_a <= ya[11:0];
        cmd.x_b <= xb[11:0];
        cmd.y_b <= yb[11:0];
        cmd.pixel_in <= pix;
        do @(posedge clk); while (!cmd.ready);
        apply_request(func, xa, ya, xb, yb, pix);
    endtask

    // Waits until every queued result has come back, then lets the engine
    // finish any blit pixel still in its pipeline.
    task automatic drain();
        @(negedge clk);
        cmd.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_size(int w, int h);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data <= w[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data <= h[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_width = w & 9'h1FF;
        shadow_height = h & 9'h1FF;
    endtask

    // Receiver stall pattern: long fully-ready stretches alternate with
    // windows of random stalls and a solid stall at the start of each window.
    always @(negedge clk)
    begin
        if (cycle_count[8:7] == 2'b00)
            rsp.ready <= 1'b1;
        else if (cycle_count[6:0] < 7'd6)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= $urandom_range(0, 2) != 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result pixel=%h done=%b", $time,
                         rsp.read_pixel, rsp.command_done);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.read_pixel !== want.read_pixel)
                begin
                    $display("%0t: read_pixel expected %h actual %h", $time,
                             want.read_pixel, rsp.read_pixel);
                    error_count++;
                end
                if (rsp.command_done !== want.command_done)
                begin
                    $display("%0t: command_done expected %b actual %b", $time,
                             want.command_done, rsp.command_done);
                    error_count++;
                end
            end
        end
    end

    function automatic int rand_coord();
        return $signed($urandom_range(0, 4095) - 2048);
    endfunction

    // Directed cases: whole-frame fills, disc edges, empty and reversed
    // boxes, zero-area blits, clipped blits, alpha extremes and reads.
    task automatic test_directed();
        send_request(FUNC_FILL_RECT, -2048, -2048, 2047, 2047, 32'h0000_0000);
        send_request(FUNC_FILL_DISC, 128, 128, 2047, 0, 32'hFFFF_FFFF);
        send_request(FUNC_FILL_DISC, 20, 20, -5, 0, 32'h1234_5678);
        send_request(FUNC_FILL_DISC, 0, 255, 3, 0, 32'hA5A5_5A5A);
        send_request(FUNC_FILL_RECT, 10, 12, 4, 5, 32'h00FF_8001);
        send_request(FUNC_FILL_RECT, 300, 5, 2047, 9, 32'hDEAD_BEEF);
        send_request(FUNC_READ, 0, 0, 0, 0, 32'h0);
        send_request(FUNC_READ, 255, 255, 0, 0, 32'h0);
        send_request(FUNC_READ, -1, 256, 0, 0, 32'h0);
        send_request(FUNC_READ, 2047, -2048, 0, 0, 32'h0);
        send_request(FUNC_SRC_PIXEL, 0, 0, 0, 0, 32'hCAFE_0001);
        send_request(FUNC_NONE_6, 0, 0, 0, 0, 32'h0);
        send_request(FUNC_NONE_7, -1, -1, -1, -1, 32'hFFFF_FFFF);
        send_request(FUNC_BLIT_COPY, 3, 3, 0, 4, 32'h0);
        send_request(FUNC_BLIT_ALPHA, 3, 3, 5, -2048, 32'h0);
        send_request(FUNC_BLIT_COPY, -1, 254, 3, 2, 32'h0);
        for (int i = 0; i < 6; i++)
            send_request(FUNC_SRC_PIXEL, 0, 0, 0, 0, 32'h0102_0304 * (i + 1));
        send_request(FUNC_BLIT_ALPHA, 10, 12, 2, 2, 32'h0);
        send_request(FUNC_SRC_PIXEL, 0, 0, 0, 0, 32'h00FF_FFFF);
        send_request(FUNC_SRC_PIXEL, 0, 0, 0, 0, 32'hFF80_4020);
        // A new start abandons the half-finished alpha blit above.
        send_request(FUNC_BLIT_ALPHA, 10, 12, 1, 1, 32'h0);
        send_request(FUNC_SRC_PIXEL, 0, 0, 0, 0, 32'h80FF_FFFF);
        send_request(FUNC_READ, 10, 12, 0, 0, 32'h0);
        send_request(FUNC_READ, 11, 13, 0, 0, 32'h0);
    endtask

    // Random traffic, mostly whole blit sequences with random content.
    task automatic test_random(int count);
        int done_items;
        int pick;
        int w;
        int h;
        int n;
        int cx;
        int cy;
        logic [2:0] f;
        done_items = 0;
        while (done_items < count)
        begin
            pick = $urandom_range(0, 99);
            cx = $urandom_range(0, frame_w() - 1);
            cy = $urandom_range(0, frame_h() - 1);
            if (pick < 35)
            begin
                w = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 6);
                h = $urandom_range(1, 5);
                f = $urandom_range(0, 1) ? FUNC_BLIT_COPY : FUNC_BLIT_ALPHA;
                send_request(f, cx - $urandom_range(0, 3), cy - $urandom_range(0, 3),
                             w, h, 32'h0);
                // Some sequences are cut short so that the next start abandons them.
                n = $urandom_range(0, 7) == 0 ? $urandom_range(0, w * h - 1) : w * h;
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        send_request(FUNC_READ, $urandom_range(0, frame_w() - 1),
                                     $urandom_range(0, frame_h() - 1), 0, 0, $urandom);
                        done_items++;
                    end
                    send_request(FUNC_SRC_PIXEL, rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), $urandom);
                end
                done_items += n + 1;
            end
            else if (pick < 50)
            begin
                send_request(FUNC_FILL_RECT, cx + $urandom_range(0, 16) - 8,
                             cy + $urandom_range(0, 16) - 8,
                             cx + $urandom_range(0, 16) - 8,
                             cy + $urandom_range(0, 16) - 8, $urandom);
                done_items++;
            end
            else if (pick < 60)
            begin
                send_request(FUNC_FILL_DISC, cx, cy, $urandom_range(0, 9) - 1, rand_coord(),
                             $urandom);
                done_items++;
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_request(FUNC_READ, rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), $urandom);
                else
                    send_request(FUNC_READ, cx, cy, rand_coord(), rand_coord(), $urandom);
                done_items++;
            end
            else if (pick < 88)
            begin
                // Empty boxes with full-range coordinates.
                send_request(FUNC_FILL_RECT, 2047 - $urandom_range(0, 1000), rand_coord(),
                             2047 - $urandom_range(0, 1000), rand_coord(), $urandom);
                send_request(FUNC_FILL_DISC, rand_coord(), rand_coord(),
                             -$urandom_range(1, 2048), rand_coord(), $urandom);
                done_items += 2;
            end
            else if (pick < 92)
            begin
                send_request($urandom_range(0, 1) ? FUNC_BLIT_COPY : FUNC_BLIT_ALPHA,
                             rand_coord(), rand_coord(), -$urandom_range(0, 2048),
                             rand_coord(), $urandom);
                done_items++;
            end
            else
            begin
                // Ignored requests: spare codes and, while idle, stray pixels.
                f = $urandom_range(0, 1) ? FUNC_NONE_6 : FUNC_NONE_7;
                if (blit_mode == BLIT_IDLE && $urandom_range(0, 1))
                    f = FUNC_SRC_PIXEL;
                send_request(f, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_IDX_WIDTH;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.func = FUNC_READ;
        cmd.x_a = '0;
        cmd.y_a = '0;
        cmd.x_b = '0;
        cmd.y_b = '0;
        cmd.pixel_in = '0;
        rsp.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 0;
        shadow_width = 256;
        shadow_height = 256;
        blit_mode = BLIT_IDLE;
        blit_x0 = 0;
        blit_y0 = 0;
        blit_w = 0;
        blit_h = 0;
        blit_col = 0;
        blit_row = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_frame[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first directed fill covers the whole memory, so every later
        // read at any frame size hits a written entry.
        test_directed();
        test_random(260);
        set_frame_size(1, 1);
        test_random(120);
        set_frame_size(0, 511);
        test_random(120);
        set_frame_size(37, 19);
        test_random(200);
        set_frame_size(256, 1);
        test_random(120);
        set_frame_size(300, 256);
        test_random(140);
        set_frame_size(256, 256);
        test_random(120);

        drain();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
